// ----- rtl/marching_tetrahedra_polygonizer_core_assert.svh -----
// Assertion macros for the polygonizer core RTL.
// Depends on nothing; include inside a module body.
`ifndef MARCHING_TETRAHEDRA_POLYGONIZER_CORE_ASSERT_SVH
`define MARCHING_TETRAHEDRA_POLYGONIZER_CORE_ASSERT_SVH

// Same-cycle implication under reset
`define MTP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Plain invariant under reset
`define MTP_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ----- rtl/mtp_pkg.sv -----
// Shared constants, case tables and types for the tetrahedra polygonizer.
// No dependencies.
`default_nettype none
package mtp_pkg;

	localparam int GRID_SIDE_DEF   = 32;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int HALF_W = 12;
	localparam int OFF_W  = 5;
	localparam int IDX_W  = 5;
	localparam int QW     = 13;  // edge offset magnitude, at most 2*half_cell
	localparam int CW     = 20;  // cell center coordinate
	localparam int PW     = 21;  // corner coordinate
	localparam int OUT_W  = 16;
	localparam int NSLOT  = 10;  // two triangle slots per tetrahedron

	localparam logic [HALF_W-1:0] HALF_CELL_RST   = 12'd307;
	localparam logic [OFF_W-1:0]  GRID_OFFSET_RST = 5'd5;

	localparam logic REG_HALF_CELL   = 1'b0;
	localparam logic REG_GRID_OFFSET = 1'b1;

	// points per tetrahedron case
	localparam logic [2:0] EDGE_NP [16] = '{
		3'd0, 3'd3, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd3,
		3'd3, 3'd4, 3'd4, 3'd3, 3'd4, 3'd3, 3'd3, 3'd0
	};

	// crossing edges, coded {from[1:0], to[1:0]} over tetra corner slots
	localparam logic [3:0] EDGE_CODE [16][4] = '{
		'{4'd0,  4'd0,  4'd0,  4'd0},
		'{4'd3,  4'd2,  4'd1,  4'd0},
		'{4'd4,  4'd7,  4'd6,  4'd0},
		'{4'd3,  4'd7,  4'd6,  4'd2},
		'{4'd9,  4'd8,  4'd11, 4'd0},
		'{4'd3,  4'd11, 4'd9,  4'd1},
		'{4'd7,  4'd11, 4'd8,  4'd4},
		'{4'd3,  4'd7,  4'd11, 4'd0},
		'{4'd12, 4'd13, 4'd14, 4'd0},
		'{4'd1,  4'd13, 4'd14, 4'd2},
		'{4'd4,  4'd12, 4'd14, 4'd6},
		'{4'd2,  4'd6,  4'd14, 4'd0},
		'{4'd8,  4'd12, 4'd13, 4'd9},
		'{4'd1,  4'd9,  4'd13, 4'd0},
		'{4'd4,  4'd8,  4'd12, 4'd0},
		'{4'd0,  4'd0,  4'd0,  4'd0}
	};

	// cube corners of each tetrahedron, normal and flipped split
	localparam logic [2:0] SPLIT [2][5][4] = '{
		'{'{3'd0, 3'd4, 3'd5, 3'd7}, '{3'd5, 3'd6, 3'd2, 3'd7},
		  '{3'd0, 3'd5, 3'd1, 3'd2}, '{3'd0, 3'd2, 3'd3, 3'd7},
		  '{3'd0, 3'd5, 3'd2, 3'd7}},
		'{'{3'd0, 3'd4, 3'd3, 3'd1}, '{3'd4, 3'd6, 3'd1, 3'd5},
		  '{3'd1, 3'd6, 3'd3, 3'd2}, '{3'd4, 3'd6, 3'd3, 3'd7},
		  '{3'd4, 3'd6, 3'd3, 3'd1}}
	};

	// corner offset direction, bit 0 x, bit 1 y, bit 2 z; 1 means +half_cell
	localparam logic [2:0] CORNER_POS [8] = '{
		3'b000, 3'b001, 3'b011, 3'b010, 3'b100, 3'b101, 3'b111, 3'b110
	};

	typedef struct packed {
		logic                  valid;
		logic                  last;
		logic [2:0][2:0]       cu;
		logic [2:0][2:0]       cv;
		logic [2:0][IDX_W-1:0] idx;
	} issue_t;

	typedef struct packed {
		logic [2:0][PW-1:0] p0;
		logic [2:0]         differ;
		logic [2:0]         neg;
	} side_pt_t;

	typedef struct packed {
		logic            valid;
		logic            last;
		side_pt_t [2:0]  pt;
	} side_t;

endpackage
`default_nettype wire

// ----- rtl/marching_tetrahedra_polygonizer_core.sv -----
// Triangles leave via hold, issue, stage 2-4, divider and output registers.
// A cell holds the issue slot while its triangles issue, at most NSLOT; the
// next cell is taken on the edge its last triangle issues, one triangle a cycle.
// Results cannot be stalled; the strobe lasts one cycle per triangle.
// Reset clears the issue register and stage valids (not later sideband), loads half_cell=307, grid_offset=5.
// Top level: config, geometry stages, three dividers, output assembly.
`default_nettype none
module marching_tetrahedra_polygonizer_core #(
	parameter int GRID_SIDE   = mtp_pkg::GRID_SIDE_DEF,
	parameter int SAMPLE_BITS = mtp_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic                              cfg_index,
	input  wire logic [mtp_pkg::HALF_W-1:0]        cfg_data,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [mtp_pkg::IDX_W-1:0]         cell_x,
	input  wire logic [mtp_pkg::IDX_W-1:0]         cell_y,
	input  wire logic [mtp_pkg::IDX_W-1:0]         cell_z,
	input  wire logic                              flipped,
	input  wire logic signed [SAMPLE_BITS-1:0]     sample_0,
	input  wire logic signed [SAMPLE_BITS-1:0]     sample_1,
	input  wire logic signed [SAMPLE_BITS-1:0]     sample_2,
	input  wire logic signed [SAMPLE_BITS-1:0]     sample_3,
	input  wire logic signed [SAMPLE_BITS-1:0]     sample_4,
	input  wire logic signed [SAMPLE_BITS-1:0]     sample_5,
	input  wire logic signed [SAMPLE_BITS-1:0]     sample_6,
	input  wire logic signed [SAMPLE_BITS-1:0]     sample_7,
	output logic                                   tri_valid,
	output logic signed [mtp_pkg::OUT_W-1:0]       ax,
	output logic signed [mtp_pkg::OUT_W-1:0]       ay,
	output logic signed [mtp_pkg::OUT_W-1:0]       az,
	output logic signed [mtp_pkg::OUT_W-1:0]       bx,
	output logic signed [mtp_pkg::OUT_W-1:0]       by,
	output logic signed [mtp_pkg::OUT_W-1:0]       bz,
	output logic signed [mtp_pkg::OUT_W-1:0]       cx,
	output logic signed [mtp_pkg::OUT_W-1:0]       cy,
	output logic signed [mtp_pkg::OUT_W-1:0]       cz,
	output logic                                   last_triangle
);
	import mtp_pkg::*;
	`include "marching_tetrahedra_polygonizer_core_assert.svh"

	localparam int SW = SAMPLE_BITS;
	localparam int MW = SW + 14;   // 4*half_cell times |s0|
	localparam int NW = SW + 15;   // dividend
	localparam int DW = SW + 1;    // divisor 2*|s1-s0|
	localparam int PIPE_LAT = QW + 4;

	// configuration registers
	logic [HALF_W-1:0] half_q;
	logic [OFF_W-1:0]  off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_CELL_RST;
			off_q  <= GRID_OFFSET_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HALF_CELL:   half_q <= cfg_data;
				REG_GRID_OFFSET: off_q  <= cfg_data[OFF_W-1:0];
				default: ;
			endcase
		end
	end

	// issue
	issue_t                      ctl_s1;
	logic [2:0][SW-1:0]          su_s1, sv_s1;
	logic [7:0][SW-1:0]          smp;
	logic [2:0][IDX_W-1:0]       idx_in;

	assign smp    = {sample_7, sample_6, sample_5, sample_4,
	                 sample_3, sample_2, sample_1, sample_0};
	assign idx_in = {cell_z, cell_y, cell_x};

	mtp_issue #(.SAMPLE_BITS(SW)) u_issue (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.flipped(flipped),
		.idx    (idx_in),
		.sample (smp),
		.ctl_s1 (ctl_s1),
		.su_s1  (su_s1),
		.sv_s1  (sv_s1)
	);

	// stage 2: magnitudes, cell centers, corner directions
	logic              v_s2, last_s2;
	logic [2:0][SW-1:0] a_s2, sd_s2;
	logic [2:0]        zero_s2;
	logic [2:0][2:0]   pu_s2, differ_s2, neg_s2;
	logic signed [CW-1:0] ctr_s2 [3];

	logic [SW-1:0]        a_c [3];
	logic [SW-1:0]        sd_c [3];
	logic signed [SW:0]   dd_c [3];
	logic signed [CW-1:0] ctr_c [3];
	logic [IDX_W-1:0]     idx_c [3];
	logic signed [IDX_W:0] dif_c [3];
	logic signed [HALF_W+1:0] h2;

	assign h2 = $signed({1'b0, half_q, 1'b0});

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			a_c[j]  = su_s1[j][SW-1] ? (~su_s1[j] + SW'(1)) : su_s1[j];
			dd_c[j] = $signed({sv_s1[j][SW-1], sv_s1[j]}) - $signed({su_s1[j][SW-1], su_s1[j]});
			sd_c[j] = dd_c[j][SW] ? SW'(-dd_c[j]) : dd_c[j][SW-1:0];
		end
		for (int k = 0; k < 3; k++) begin
			idx_c[k] = ctl_s1.idx[k];
			if (int'(idx_c[k]) > GRID_SIDE - 1) idx_c[k] = IDX_W'(GRID_SIDE - 1);
			dif_c[k] = $signed({1'b0, idx_c[k]}) - $signed({1'b0, off_q});
			ctr_c[k] = dif_c[k] * h2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		last_s2 <= ctl_s1.last;
		for (int j = 0; j < 3; j++) begin
			a_s2[j]      <= a_c[j];
			sd_s2[j]     <= sd_c[j];
			zero_s2[j]   <= (dd_c[j] == '0);
			pu_s2[j]     <= CORNER_POS[ctl_s1.cu[j]];
			differ_s2[j] <= CORNER_POS[ctl_s1.cu[j]] ^ CORNER_POS[ctl_s1.cv[j]];
			neg_s2[j]    <= CORNER_POS[ctl_s1.cu[j]] & ~CORNER_POS[ctl_s1.cv[j]];
			ctr_s2[j]    <= ctr_c[j];
		end
	end

	// stage 3: scale numerator, place start corners
	logic               v_s3;
	logic [2:0][MW-1:0] prod_s3;
	logic [2:0][SW-1:0] sd_s3;
	logic [2:0]         zero_s3;
	side_t              side_s3;
	logic signed [PW-1:0] hx;

	assign hx = $signed(PW'(half_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s3.valid <= v_s2;
		side_s3.last  <= last_s2;
		for (int j = 0; j < 3; j++) begin
			prod_s3[j] <= MW'({half_q, 2'b00}) * MW'(a_s2[j]);
			sd_s3[j]   <= sd_s2[j];
			zero_s3[j] <= zero_s2[j];
			side_s3.pt[j].differ <= differ_s2[j];
			side_s3.pt[j].neg    <= neg_s2[j];
			for (int k = 0; k < 3; k++)
				side_s3.pt[j].p0[k] <= PW'(ctr_s2[k]) + (pu_s2[j][k] ? hx : -hx);
		end
	end

	// stage 4: dividend with rounding half, divisor
	logic               v_s4;
	logic [2:0][NW-1:0] num_s4;
	logic [2:0][DW-1:0] den_s4;
	logic [2:0]         zero_s4;
	side_t              side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s4 <= side_s3;
		for (int j = 0; j < 3; j++) begin
			num_s4[j]  <= NW'(prod_s3[j]) + NW'(sd_s3[j]);
			den_s4[j]  <= {sd_s3[j], 1'b0};
			zero_s4[j] <= zero_s3[j];
		end
	end

	// dividers, one per triangle vertex
	logic [2:0]          dv;
	logic [2:0][QW-1:0]  q;

	for (genvar j = 0; j < 3; j++) begin : g_div
		mtp_div #(.NW(NW), .DW(DW)) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (v_s4),
			.num      (num_s4[j]),
			.den      (den_s4[j]),
			.zero     (zero_s4[j]),
			.out_valid(dv[j]),
			.quo      (q[j])
		);
	end

	// carry corners alongside the dividers
	side_t side_d [QW];

	always_ff @(posedge clk) begin
		side_d[0] <= side_s4;
		for (int i = 1; i < QW; i++)
			side_d[i] <= side_d[i-1];
	end

	// output: offset along crossing axes, saturate
	logic signed [OUT_W-1:0] crd [3][3];
	logic signed [PW:0]      sum_c [3][3];
	logic signed [PW:0]      dq_c [3][3];
	logic signed [PW:0]      qe_c [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			qe_c[j] = $signed({{(PW+1-QW){1'b0}}, q[j]});
			for (int k = 0; k < 3; k++) begin
				if (!side_d[QW-1].pt[j].differ[k])
					dq_c[j][k] = '0;
				else if (side_d[QW-1].pt[j].neg[k])
					dq_c[j][k] = -qe_c[j];
				else
					dq_c[j][k] = qe_c[j];
				sum_c[j][k] = $signed({side_d[QW-1].pt[j].p0[k][PW-1],
				                       side_d[QW-1].pt[j].p0[k]}) + dq_c[j][k];
				if (sum_c[j][k] > $signed((PW+1)'(32767)))
					crd[j][k] = 16'sh7fff;
				else if (sum_c[j][k] < -$signed((PW+1)'(32768)))
					crd[j][k] = -16'sh8000;
				else
					crd[j][k] = sum_c[j][k][OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tri_valid <= 1'b0;
		end else begin
			tri_valid <= dv[0];
		end
	end

	always_ff @(posedge clk) begin
		last_triangle <= side_d[QW-1].last;
		ax <= crd[0][0]; ay <= crd[0][1]; az <= crd[0][2];
		bx <= crd[1][0]; by <= crd[1][1]; bz <= crd[1][2];
		cx <= crd[2][0]; cy <= crd[2][1]; cz <= crd[2][2];
	end

	// checks
	`MTP_ASSERT_ALWAYS(a_div_lockstep, clk, arst_n, (dv[0] == dv[1]) && (dv[0] == dv[2]),
		"dividers out of step")
	`MTP_ASSERT_IMPLY(a_side_align, clk, arst_n, dv[0], side_d[QW-1].valid,
		"corner sideband misaligned with quotient")
	`MTP_ASSERT_ALWAYS(a_pipe_lat, clk, arst_n, tri_valid == ($past(ctl_s1.valid, PIPE_LAT) === 1'b1),
		"triangle strobe does not match issue")

endmodule
`default_nettype wire

// ----- rtl/mtp_issue.sv -----
// Cell hold register and triangle sequencer: one triangle issued per cycle.
// Depends on mtp_pkg.
`default_nettype none
module mtp_issue #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                flipped,
	input  wire logic [2:0][mtp_pkg::IDX_W-1:0]      idx,
	input  wire logic [7:0][SAMPLE_BITS-1:0]         sample,
	output mtp_pkg::issue_t                          ctl_s1,
	output logic [2:0][SAMPLE_BITS-1:0]              su_s1,
	output logic [2:0][SAMPLE_BITS-1:0]              sv_s1
);
	import mtp_pkg::*;

	function automatic logic [NSLOT-1:0] slot_mask(input logic [7:0] neg, input logic par);
		logic [NSLOT-1:0] m;
		logic [3:0]       tb;
		m = '0;
		for (int t = 0; t < 5; t++) begin
			for (int j = 0; j < 4; j++)
				tb[j] = neg[SPLIT[par][t][j]];
			m[2*t]   = (EDGE_NP[tb] != 3'd0);
			m[2*t+1] = (EDGE_NP[tb] == 3'd4);
		end
		return m;
	endfunction

	logic                         hold_v_q;
	logic [NSLOT-1:0]             mask_q;
	logic                         par_q;
	logic [2:0][IDX_W-1:0]        idx_q;
	logic [7:0][SAMPLE_BITS-1:0]  smp_q;

	logic [7:0]       in_neg, neg_q;
	logic [NSLOT-1:0] in_mask, sel;
	logic [3:0]       slot;
	logic [2:0]       tet;
	logic [3:0]       tb;
	logic [1:0]       pick [3];
	logic [3:0]       ecode [3];
	logic [2:0]       cu [3];
	logic [2:0]       cv [3];
	logic             last, accept;

	always_comb begin
		for (int c = 0; c < 8; c++) begin
			in_neg[c] = sample[c][SAMPLE_BITS-1];
			neg_q[c]  = smp_q[c][SAMPLE_BITS-1];
		end
	end
	assign in_mask = slot_mask(in_neg, flipped);

	// pick the lowest pending slot
	always_comb begin
		slot = '0;
		for (int i = NSLOT - 1; i >= 0; i--)
			if (mask_q[i]) slot = 4'(i);
	end
	assign sel  = NSLOT'(1) << slot;
	assign last = ((mask_q & (mask_q - NSLOT'(1))) == '0);
	assign busy = hold_v_q && !last;
	assign accept = start && !busy;
	assign tet  = slot[3:1];

	// resolve the triangle's edges, one per vertex, to cube corners
	always_comb begin
		for (int j = 0; j < 4; j++)
			tb[j] = neg_q[SPLIT[par_q][tet][j]];
		if (EDGE_NP[tb] == 3'd3) begin
			pick[0] = 2'd0; pick[1] = 2'd1; pick[2] = 2'd2;
		end else if (!slot[0]) begin
			pick[0] = 2'd0; pick[1] = 2'd1; pick[2] = 2'd3;
		end else begin
			pick[0] = 2'd1; pick[1] = 2'd2; pick[2] = 2'd3;
		end
		for (int j = 0; j < 3; j++) begin
			ecode[j] = EDGE_CODE[tb][pick[j]];
			cu[j]    = SPLIT[par_q][tet][ecode[j][3:2]];
			cv[j]    = SPLIT[par_q][tet][ecode[j][1:0]];
		end
	end

	// hold the cell and walk its slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			mask_q   <= '0;
		end else if (accept) begin
			hold_v_q <= (in_mask != '0);
			mask_q   <= in_mask;
		end else if (hold_v_q) begin
			hold_v_q <= !last;
			mask_q   <= mask_q & ~sel;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			par_q <= flipped;
			idx_q <= idx;
			smp_q <= sample;
		end
	end

	// issue register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= hold_v_q;
			ctl_s1.last  <= last;
			ctl_s1.idx   <= idx_q;
			for (int j = 0; j < 3; j++) begin
				ctl_s1.cu[j] <= cu[j];
				ctl_s1.cv[j] <= cv[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			su_s1[j] <= smp_q[cu[j]];
			sv_s1[j] <= smp_q[cv[j]];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/mtp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on mtp_pkg.
`default_nettype none
module mtp_div #(
	parameter int NW = 31,
	parameter int DW = 17
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire logic [NW-1:0]          num,
	input  wire logic [DW-1:0]          den,
	input  wire logic                   zero,
	output logic                        out_valid,
	output logic [mtp_pkg::QW-1:0]      quo
);
	import mtp_pkg::*;

	logic [QW-1:0]          v_s;
	logic [QW-1:0][NW-1:0]  rem_s;
	logic [QW-1:0][DW-1:0]  den_s;
	logic [QW-1:0][QW-1:0]  q_s;
	logic [QW-1:0]          zero_s;

	for (genvar g = 0; g < QW; g++) begin : g_step
		logic [NW-1:0] rin, trial;
		logic [DW-1:0] din;
		logic [QW-1:0] qin;
		logic          zin, vin, ge;
		if (g == 0) begin : g_first
			assign rin = num;
			assign din = den;
			assign qin = '0;
			assign zin = zero;
			assign vin = in_valid;
		end else begin : g_next
			assign rin = rem_s[g-1];
			assign din = den_s[g-1];
			assign qin = q_s[g-1];
			assign zin = zero_s[g-1];
			assign vin = v_s[g-1];
		end
		// trial subtract of the shifted divisor
		assign trial = NW'(din) << (QW - 1 - g);
		assign ge    = (rin >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else begin
				v_s[g] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g]  <= ge ? rin - trial : rin;
			den_s[g]  <= din;
			q_s[g]    <= {qin[QW-2:0], ge};
			zero_s[g] <= zin;
		end
	end

	assign out_valid = v_s[QW-1];
	assign quo = zero_s[QW-1] ? '0 : q_s[QW-1];

endmodule
`default_nettype wire
